>>> rtl/fpc_pkg.sv
// Package for the frame pacing clock: widths, event and register codes,
// the controller state type and the command/status structs.
// No dependencies; every other file of the block but fpc_div imports it.
package fpc_pkg;

	localparam int DELTA_WINDOW_DEF = 16;

	localparam int FUNC_W     = 2;
	localparam int TIME_W     = 32;
	localparam int RATE_W     = 16;
	localparam int FPS_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Shared divider: 48-bit product over a divisor of up to 32 bits.
	localparam int PROD_W  = TIME_W + RATE_W;
	localparam int DIV_D_W = 32;

	localparam int MS_W = 10;
	localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;
	localparam int FPS_SCALE = 16000;
	localparam logic [FPS_W-1:0] FPS_ONE = 16'd16;
	localparam logic [FPS_W-1:0] FPS_MAX = 16'hFFFF;

	// Result word layout, lowest bit first.
	localparam int OFS_FRAME  = 0;
	localparam int OFS_DELTA  = 32;
	localparam int OFS_FPS    = 64;
	localparam int OFS_SCHED  = 80;
	localparam int OFS_PAUSED = 112;
	localparam int OUT_FIELDS_W = 113;
	localparam int M_TDATA_W  = 120;
	localparam int PAD_W      = M_TDATA_W - OUT_FIELDS_W;
	localparam int S_TDATA_W  = 32;

	localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PAUSE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESUME = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LOCK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_BASE   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVENT,
		ST_LMUL,
		ST_LSTART,
		ST_LWAIT,
		ST_LCHECK,
		ST_RRD,
		ST_RWR,
		ST_SCHED,
		ST_START2,
		ST_WAIT2,
		ST_FINISH
	} fpc_state_t;

	typedef struct packed {
		logic capture;
		logic event_step;
		logic lock_mul;
		logic lock_start;
		logic ring_rd;
		logic ring_wr;
		logic sched_step;
		logic fin_start;
		logic load_out;
	} fpc_cmd_t;

	typedef struct packed {
		logic is_frame;
		logic lock_on;
		logic busy;
		logic refuse;
	} fpc_status_t;

endpackage

>>> rtl/fpc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module fpc_div #(
	parameter int N_W = 48,
	parameter int D_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [N_W-1:0] quotient
);

	localparam int CW = $clog2(N_W + 1);

	logic [CW-1:0]  cnt_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dsr_q;
	logic [N_W-1:0] quo_q;
	logic [D_W:0]   trial;
	logic           fits;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(N_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? D_W'(trial - {1'b0, dsr_q}) : trial[D_W-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

>>> rtl/fpc_datapath.sv
// Datapath of the frame pacing clock: configuration, pacing state, delta ring,
// multipliers, the two serial dividers and the result register.
// Depends on fpc_pkg and fpc_div.
module fpc_datapath
	import fpc_pkg::*;
#(
	parameter int DELTA_WINDOW = DELTA_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [FUNC_W-1:0]     func,
	input  logic [TIME_W-1:0]     now_ms,
	input  fpc_cmd_t              cmd,
	output fpc_status_t           status,
	output logic [M_TDATA_W-1:0]  res_data,
	output logic                  res_adv
);

	localparam int PW      = (DELTA_WINDOW > 1) ? $clog2(DELTA_WINDOW) : 1;
	localparam int FPS_NUM = FPS_SCALE * DELTA_WINDOW;
	localparam int FW      = $clog2(FPS_NUM + 1);

	logic              lock_en_q;
	logic [RATE_W-1:0] lock_rate_q;
	logic [RATE_W-1:0] lock_base_q;

	logic [TIME_W-1:0] frame_cnt_q;
	logic [TIME_W-1:0] last_time_q;
	logic              anchored_q;
	logic [TIME_W-1:0] anchor_time_q;
	logic [TIME_W-1:0] anchor_frame_q;
	logic              paused_q;
	logic [TIME_W-1:0] pause_start_q;
	logic [TIME_W-1:0] pause_sum_q;
	logic [TIME_W-1:0] delta_sum_q;
	logic [DELTA_WINDOW-1:0] vld_q;
	logic [PW-1:0]     ptr_q;

	logic [FUNC_W-1:0]  func_q;
	logic [TIME_W-1:0]  now_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DIV_D_W-1:0] dsr_q;
	logic [TIME_W-1:0]  rd_q;
	logic [TIME_W-1:0]  delta_q;
	logic               adv_q;
	logic               direct_q;

	logic [TIME_W-1:0] ring_mem [DELTA_WINDOW];

	logic [RATE_W-1:0] eff_base;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] frames_since;
	logic [TIME_W-1:0] old_delta;
	logic [TIME_W-1:0] target;
	logic [PW-1:0]     ptr_next;
	logic              start_a;
	logic              busy_a;
	logic              busy_b;
	logic [PROD_W-1:0] quo_a;
	logic [FW-1:0]     quo_b;
	logic [FPS_W-1:0]  fps;
	logic [TIME_W-1:0] sched;

	assign eff_base     = (lock_base_q == '0) ? RATE_W'(1) : lock_base_q;
	assign elapsed      = now_q - anchor_time_q;
	assign frames_since = frame_cnt_q - anchor_frame_q;
	assign old_delta    = vld_q[ptr_q] ? rd_q : '0;
	assign target       = anchor_frame_q + quo_a[TIME_W-1:0];

	// The slot index follows frame_count mod DELTA_WINDOW, also across the wrap
	// of the 32-bit frame count.
	assign ptr_next = (ptr_q == PW'(DELTA_WINDOW - 1) || frame_cnt_q == '1) ?
		'0 : ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_en_q   <= 1'b0;
			lock_rate_q <= RATE_W'(30);
			lock_base_q <= RATE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCK_ENABLE: lock_en_q   <= cfg_data[0];
				REG_LOCK_RATE:   lock_rate_q <= cfg_data;
				REG_LOCK_BASE:   lock_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q    <= '0;
			last_time_q    <= '0;
			anchored_q     <= 1'b0;
			anchor_time_q  <= '0;
			anchor_frame_q <= '0;
			paused_q       <= 1'b0;
			pause_start_q  <= '0;
			pause_sum_q    <= '0;
			delta_sum_q    <= '0;
			vld_q          <= '0;
			ptr_q          <= '0;
		end else if (cmd.event_step) begin
			case (func_q)
				FUNC_FRAME: begin
					// A frame request ends any pause before it is paced.
					if (paused_q) begin
						paused_q    <= 1'b0;
						pause_sum_q <= pause_sum_q + (now_q - pause_start_q);
					end
					if (lock_en_q && !anchored_q) begin
						anchored_q     <= 1'b1;
						anchor_frame_q <= frame_cnt_q;
						anchor_time_q  <= now_q;
					end
				end
				FUNC_PAUSE: begin
					if (!paused_q) begin
						paused_q      <= 1'b1;
						pause_start_q <= now_q;
					end
				end
				FUNC_RESUME: begin
					if (paused_q) begin
						paused_q    <= 1'b0;
						pause_sum_q <= pause_sum_q + (now_q - pause_start_q);
					end
				end
				default: ;
			endcase
		end else if (cmd.ring_wr) begin
			delta_sum_q   <= delta_sum_q - old_delta + delta_q;
			vld_q[ptr_q]  <= 1'b1;
			pause_sum_q   <= '0;
			last_time_q   <= now_q;
			frame_cnt_q   <= frame_cnt_q + 1'b1;
			ptr_q         <= ptr_next;
		end else if (cmd.sched_step) begin
			if (!lock_en_q) begin
				anchored_q <= 1'b0;
			end else if (!anchored_q) begin
				anchored_q     <= 1'b1;
				anchor_frame_q <= frame_cnt_q;
				anchor_time_q  <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			now_q  <= now_ms;
			adv_q  <= 1'b0;
		end
		if (cmd.lock_mul) begin
			prod_q <= PROD_W'(elapsed) * PROD_W'(lock_rate_q);
			dsr_q  <= DIV_D_W'(eff_base) * DIV_D_W'(MS_PER_S);
		end
		if (cmd.ring_rd) begin
			delta_q <= now_q - last_time_q - pause_sum_q;
		end
		if (cmd.ring_wr) begin
			adv_q <= 1'b1;
		end
		if (cmd.sched_step) begin
			prod_q   <= PROD_W'(frames_since) * PROD_W'(lock_rate_q);
			dsr_q    <= DIV_D_W'(eff_base);
			direct_q <= !lock_en_q || !anchored_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_wr) begin
			ring_mem[ptr_q] <= delta_q;
		end
		if (cmd.ring_rd) begin
			rd_q <= ring_mem[ptr_q];
		end
	end

	// Unit A serves the lock test and then the schedule; unit B the frame rate.
	assign start_a = cmd.lock_start || (cmd.fin_start && !direct_q);

	fpc_div #(
		.N_W(PROD_W),
		.D_W(DIV_D_W)
	) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_a),
		.dividend (prod_q),
		.divisor  (dsr_q),
		.busy     (busy_a),
		.quotient (quo_a)
	);

	fpc_div #(
		.N_W(FW),
		.D_W(TIME_W)
	) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.fin_start),
		.dividend (FW'(FPS_NUM)),
		.divisor  (delta_sum_q),
		.busy     (busy_b),
		.quotient (quo_b)
	);

	always_comb begin
		if (delta_sum_q == '0) begin
			fps = FPS_ONE;
		end else if (quo_b > FW'(FPS_MAX) && FW > FPS_W) begin
			fps = FPS_MAX;
		end else begin
			fps = FPS_W'(quo_b);
		end
	end

	assign sched = direct_q ? now_q : anchor_time_q + quo_a[TIME_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_data <= {PAD_W'(0), paused_q, sched, fps,
				(adv_q ? delta_q : TIME_W'(0)), frame_cnt_q};
			res_adv  <= adv_q;
		end
	end

	assign status.is_frame = func_q == FUNC_FRAME;
	assign status.lock_on  = lock_en_q;
	assign status.busy     = busy_a || busy_b;
	assign status.refuse   = target < frame_cnt_q;

endmodule

>>> rtl/fpc_ctrl.sv
// Controller of the frame pacing clock: sequences one request through the
// datapath and holds the output valid flag. Depends on fpc_pkg.
module fpc_ctrl
	import fpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  fpc_status_t status,
	output fpc_cmd_t    cmd
);

	fpc_state_t state_q;
	fpc_state_t state_d;
	logic       out_valid_q;
	logic       can_load;

	// A finished result may replace the one leaving in the same cycle.
	assign can_load = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_EVENT;
			ST_EVENT: begin
				if (!status.is_frame) begin
					state_d = ST_SCHED;
				end else if (status.lock_on) begin
					state_d = ST_LMUL;
				end else begin
					state_d = ST_RRD;
				end
			end
			ST_LMUL:   state_d = ST_LSTART;
			ST_LSTART: state_d = ST_LWAIT;
			ST_LWAIT:  if (!status.busy) state_d = ST_LCHECK;
			ST_LCHECK: state_d = status.refuse ? ST_SCHED : ST_RRD;
			ST_RRD:    state_d = ST_RWR;
			ST_RWR:    state_d = ST_SCHED;
			ST_SCHED:  state_d = ST_START2;
			ST_START2: state_d = ST_WAIT2;
			ST_WAIT2:  if (!status.busy) state_d = ST_FINISH;
			ST_FINISH: if (can_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_EVENT:  cmd.event_step = 1'b1;
			ST_LMUL:   cmd.lock_mul   = 1'b1;
			ST_LSTART: cmd.lock_start = 1'b1;
			ST_RRD:    cmd.ring_rd    = 1'b1;
			ST_RWR:    cmd.ring_wr    = 1'b1;
			ST_SCHED:  cmd.sched_step = 1'b1;
			ST_START2: cmd.fin_start  = 1'b1;
			ST_FINISH: cmd.load_out   = can_load;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> rtl/frame_pacing_clock.sv
// Frame pacing clock. Request-to-result latency depends on the event and the lock mode: with
// lock off the frame-rate divider sets it, over FPS_BITS, the width of 16000*DELTA_WINDOW
// (18 at the default); with lock on and anchored the 48-step divider sets it, once for the
// schedule and, for a frame, once more for the lock test. One request is worked at a time;
// the next is taken in the cycle after a result is loaded, while it waits in the output register.
// Async active-low reset clears only the controller, configuration and pacing state registers.
module frame_pacing_clock
	import fpc_pkg::*;
#(
	parameter int DELTA_WINDOW = DELTA_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] now_ms
	input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] frame_number, [63:32] delta_ms, [79:64] fps_q4,
	// [111:80] scheduled_ms, [112] is_paused, [119:113] zero
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tuser    // [0] advanced
);

	fpc_cmd_t    cmd;
	fpc_status_t status;

	fpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fpc_datapath #(
		.DELTA_WINDOW(DELTA_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.func      (s_tuser),
		.now_ms    (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.res_data  (m_tdata),
		.res_adv   (m_tuser)
	);

endmodule

>>> rtl/fpc_checker.sv
// Port-level checks for the frame pacing clock, bound to the top level.
// Depends on fpc_pkg and frame_pacing_clock.
module fpc_checker
	import fpc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	logic [1:0] pending_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// Requests taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (s_acc && !m_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (m_acc && !s_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result shown without a matching request");

	a_delta_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[OFS_DELTA +: TIME_W] == '0)
		else $error("delta given for a frame that did not advance");

	a_adv_unpaused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[OFS_PAUSED])
		else $error("advanced frame reported while paused");

endmodule

bind frame_pacing_clock fpc_checker u_fpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for frame_pacing_clock: a short table of directed requests, then random event
// streams under several lock settings, each result checked against a value given in the table
// or an in-bench predictor. Depends on fpc_pkg and the frame_pacing_clock RTL only.
module tb;
	import fpc_pkg::*;

	localparam int DW = DELTA_WINDOW_DEF;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RAND_CHUNKS = 19;
	localparam int CHUNK_LEN = 100;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        adv;
		logic [31:0] frame;
		logic [31:0] delta;
		logic [15:0] fps;
		logic [31:0] sched;
		logic        paused;
	} pace_res_t;

	typedef enum logic {ROW_EVENT, ROW_REGS} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  func;
		logic [31:0] now;
		logic        typed;
		pace_res_t   want;
		logic        en;
		logic [15:0] rate;
		logic [15:0] base;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;

	int tx_idle = 10;
	int rx_idle = 63;
	int mismatches = 0;
	int cycles = 0;

	pace_res_t pending_results[$];
	stim_row_t dir_rows[$];

	// Predictor copy of the pacing state and registers.
	logic        p_lock_en = 1'b0;
	logic [15:0] p_rate = 16'd30;
	logic [15:0] p_base = 16'd1;
	logic [31:0] p_fc = '0;
	logic [31:0] p_last = '0;
	logic        p_anch = 1'b0;
	logic [31:0] p_anc_time = '0;
	logic [31:0] p_anc_frame = '0;
	logic        p_paused = 1'b0;
	logic [31:0] p_pstart = '0;
	logic [31:0] p_psum = '0;
	logic [31:0] p_ring [DW] = '{default: '0};
	logic [31:0] p_dsum = '0;

	frame_pacing_clock u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void end_pause(logic [31:0] now);
		if (p_paused) begin
			p_paused = 1'b0;
			p_psum = p_psum + (now - p_pstart);
		end
	endfunction

	function automatic pace_res_t pace_step(logic [1:0] func, logic [31:0] now);
		pace_res_t   r;
		logic [31:0] dlt;
		logic [31:0] tgt;
		logic [31:0] sched;
		logic [63:0] q;
		logic [63:0] eff_base;
		logic        adv;
		logic        refuse;
		int unsigned idx;
		adv = 1'b0;
		refuse = 1'b0;
		dlt = '0;
		eff_base = (p_base == 16'd0) ? 64'd1 : {48'd0, p_base};
		case (func)
			FUNC_FRAME: begin
				end_pause(now);
				if (p_lock_en) begin
					if (!p_anch) begin
						p_anch = 1'b1;
						p_anc_frame = p_fc;
						p_anc_time = now;
					end
					q = ({32'd0, now - p_anc_time} * {48'd0, p_rate}) / (eff_base * 64'd1000);
					tgt = p_anc_frame + q[31:0];
					refuse = (tgt < p_fc);
				end
				if (!refuse) begin
					dlt = now - p_last - p_psum;
					p_psum = '0;
					idx = p_fc % DW;
					p_dsum = p_dsum - p_ring[idx] + dlt;
					p_ring[idx] = dlt;
					p_last = now;
					p_fc = p_fc + 32'd1;
					adv = 1'b1;
				end
			end
			FUNC_PAUSE: begin
				if (!p_paused) begin
					p_paused = 1'b1;
					p_pstart = now;
				end
			end
			FUNC_RESUME: begin
				end_pause(now);
			end
			default: ;
		endcase
		// The schedule step runs on every request, whatever the event was.
		if (!p_lock_en) begin
			p_anch = 1'b0;
			sched = now;
		end else if (!p_anch) begin
			p_anch = 1'b1;
			p_anc_frame = p_fc;
			p_anc_time = now;
			sched = now;
		end else begin
			q = ({32'd0, p_fc - p_anc_frame} * {48'd0, p_rate}) / eff_base;
			sched = p_anc_time + q[31:0];
		end
		r.adv = adv;
		r.frame = p_fc;
		r.delta = dlt;
		if (p_dsum == 32'd0) begin
			r.fps = FPS_ONE;
		end else begin
			q = (64'd16000 * DW) / {32'd0, p_dsum};
			r.fps = (q > 64'd65535) ? FPS_MAX : q[15:0];
		end
		r.sched = sched;
		r.paused = p_paused;
		return r;
	endfunction

	function automatic stim_row_t row_ev(logic [1:0] func, logic [31:0] now);
		stim_row_t r;
		r.kind = ROW_EVENT;
		r.func = func;
		r.now = now;
		r.typed = 1'b0;
		r.want = '0;
		r.en = 1'b0;
		r.rate = '0;
		r.base = '0;
		return r;
	endfunction

	function automatic stim_row_t row_typed(logic [1:0] func, logic [31:0] now, pace_res_t want);
		stim_row_t r;
		r = row_ev(func, now);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t row_regs(logic en, logic [15:0] rate, logic [15:0] base);
		stim_row_t r;
		r = row_ev(FUNC_NONE, '0);
		r.kind = ROW_REGS;
		r.en = en;
		r.rate = rate;
		r.base = base;
		return r;
	endfunction

	task automatic send_event(input logic [1:0] func, input logic [31:0] now, input logic typed,
			input pace_res_t want);
		pace_res_t pred;
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= now;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = pace_step(func, now);
		pending_results.push_back(typed ? want : pred);
	endtask

	// Registers change only once the block has returned every result.
	task automatic apply_pacing_regs(input logic en, input logic [15:0] rate,
			input logic [15:0] base);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_LOCK_ENABLE;
		cfg_data <= {15'd0, en};
		@(posedge clk);
		cfg_index <= REG_LOCK_RATE;
		cfg_data <= rate;
		@(posedge clk);
		cfg_index <= REG_LOCK_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		p_lock_en = en;
		p_rate = rate;
		p_base = base;
	endtask

	task automatic report_mismatch(input string what, input pace_res_t want, input pace_res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%s: expected adv=%0d frame=%0d delta=%0d fps=%0d sched=%0d paused=%0d",
				what, want.adv, want.frame, want.delta, want.fps, want.sched, want.paused);
			$display("%s: actual   adv=%0d frame=%0d delta=%0d fps=%0d sched=%0d paused=%0d",
				what, got.adv, got.frame, got.delta, got.fps, got.sched, got.paused);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	always @(posedge clk) begin : result_check
		pace_res_t got;
		pace_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.adv = m_tuser;
			got.frame = m_tdata[OFS_FRAME +: TIME_W];
			got.delta = m_tdata[OFS_DELTA +: TIME_W];
			got.fps = m_tdata[OFS_FPS +: FPS_W];
			got.sched = m_tdata[OFS_SCHED +: TIME_W];
			got.paused = m_tdata[OFS_PAUSED];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("frame_pacing_clock verification failed");
			$finish;
		end
	end

	initial begin
		int          ch;
		int          k;
		int          r;
		logic [1:0]  f;
		logic [31:0] now_cur;
		logic        en;
		logic [15:0] rate;
		logic [15:0] base;

		// Free running after reset: zero delta, saturation, pause and resume handling.
		dir_rows.push_back(row_typed(FUNC_FRAME, 32'd0,
			pace_res_t'{1'b1, 32'd1, 32'd0, 16'd16, 32'd0, 1'b0}));
		dir_rows.push_back(row_typed(FUNC_FRAME, 32'd1,
			pace_res_t'{1'b1, 32'd2, 32'd1, 16'hFFFF, 32'd1, 1'b0}));
		dir_rows.push_back(row_typed(FUNC_PAUSE, 32'd150,
			pace_res_t'{1'b0, 32'd2, 32'd0, 16'hFFFF, 32'd150, 1'b1}));
		dir_rows.push_back(row_typed(FUNC_PAUSE, 32'd160,
			pace_res_t'{1'b0, 32'd2, 32'd0, 16'hFFFF, 32'd160, 1'b1}));
		dir_rows.push_back(row_typed(FUNC_RESUME, 32'd200,
			pace_res_t'{1'b0, 32'd2, 32'd0, 16'hFFFF, 32'd200, 1'b0}));
		dir_rows.push_back(row_typed(FUNC_RESUME, 32'd210,
			pace_res_t'{1'b0, 32'd2, 32'd0, 16'hFFFF, 32'd210, 1'b0}));
		dir_rows.push_back(row_typed(FUNC_NONE, 32'd220,
			pace_res_t'{1'b0, 32'd2, 32'd0, 16'hFFFF, 32'd220, 1'b0}));
		// A frame request ends a pause that is still in effect, then frame times wrap around.
		dir_rows.push_back(row_ev(FUNC_PAUSE, 32'd300));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd400));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'hFFFF_FFFF));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd5));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'h8000_0000));
		// Lock mode: anchoring, a refused early frame, then an accepted paced one.
		dir_rows.push_back(row_regs(1'b1, 16'd30, 16'd1));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd1000));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd1010));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd1034));
		dir_rows.push_back(row_ev(FUNC_NONE, 32'd2000));
		dir_rows.push_back(row_ev(FUNC_PAUSE, 32'd2100));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd3000));
		// Zero rate and a zero base, which counts as one.
		dir_rows.push_back(row_regs(1'b1, 16'd0, 16'd0));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd4000));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd9000));
		dir_rows.push_back(row_regs(1'b1, 16'hFFFF, 16'hFFFF));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd10000));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'hFFFF_FFF0));
		// Turning lock off drops the anchor.
		dir_rows.push_back(row_regs(1'b0, 16'd30, 16'd1));
		dir_rows.push_back(row_ev(FUNC_FRAME, 32'd20000));
		dir_rows.push_back(row_ev(FUNC_RESUME, 32'd20001));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REGS)
				apply_pacing_regs(dir_rows[i].en, dir_rows[i].rate, dir_rows[i].base);
			else
				send_event(dir_rows[i].func, dir_rows[i].now, dir_rows[i].typed, dir_rows[i].want);
		end

		now_cur = 32'd20001;
		for (ch = 0; ch < RAND_CHUNKS; ch++) begin
			if (ch < 6) begin
				tx_idle = 10;
				rx_idle = 63;
			end else if (ch < 12) begin
				tx_idle = 63;
				rx_idle = 10;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			en = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: rate = 16'd0;
				1: rate = 16'd1;
				2: rate = 16'd30;
				3: rate = 16'd60;
				4: rate = 16'hFFFF;
				default: rate = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 5))
				0: base = 16'd0;
				1: base = 16'd1;
				2: base = 16'd1000;
				3: base = 16'hFFFF;
				4: base = 16'($urandom_range(1, 4));
				default: base = 16'($urandom_range(0, 65535));
			endcase
			// Chunks 0 and 6 keep a rate at which paced frames get through often.
			if (ch == 0 || ch == 6) begin
				en = 1'b1;
				rate = 16'd30;
				base = 16'd1;
			end
			apply_pacing_regs(en, rate, base);
			for (k = 0; k < CHUNK_LEN; k++) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					now_cur = $urandom();
				else if (r < 7)
					now_cur = now_cur - $urandom_range(0, 500);
				else
					now_cur = now_cur + $urandom_range(0, 120);
				r = $urandom_range(0, 99);
				if (r < 62)
					f = FUNC_FRAME;
				else if (r < 77)
					f = FUNC_PAUSE;
				else if (r < 93)
					f = FUNC_RESUME;
				else
					f = FUNC_NONE;
				send_event(f, now_cur, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("frame_pacing_clock verification clean");
		end else begin
			$display("frame_pacing_clock verification failed");
		end
		$finish;
	end

endmodule
